### src/slex_pkg.sv
package slex_pkg;

   localparam int MAX_WORD_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int LEN_W = 6;
   localparam int LINE_W = 16;
   localparam int COL_W = 16;
   localparam int CHAR_W = 8;
   localparam int KIND_W = 5;

   localparam logic [KIND_W-1:0] KIND_EXIT       = 5'd0;
   localparam logic [KIND_W-1:0] KIND_VAR        = 5'd1;
   localparam logic [KIND_W-1:0] KIND_IF         = 5'd2;
   localparam logic [KIND_W-1:0] KIND_ELSE       = 5'd3;
   localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd4;
   localparam logic [KIND_W-1:0] KIND_INT        = 5'd5;
   localparam logic [KIND_W-1:0] KIND_LPAREN     = 5'd6;
   localparam logic [KIND_W-1:0] KIND_RPAREN     = 5'd7;
   localparam logic [KIND_W-1:0] KIND_LBRACE     = 5'd8;
   localparam logic [KIND_W-1:0] KIND_RBRACE     = 5'd9;
   localparam logic [KIND_W-1:0] KIND_PLUS       = 5'd10;
   localparam logic [KIND_W-1:0] KIND_MINUS      = 5'd11;
   localparam logic [KIND_W-1:0] KIND_STAR       = 5'd12;
   localparam logic [KIND_W-1:0] KIND_SLASH      = 5'd13;
   localparam logic [KIND_W-1:0] KIND_LT         = 5'd14;
   localparam logic [KIND_W-1:0] KIND_LE         = 5'd15;
   localparam logic [KIND_W-1:0] KIND_GT         = 5'd16;
   localparam logic [KIND_W-1:0] KIND_GE         = 5'd17;
   localparam logic [KIND_W-1:0] KIND_BANG       = 5'd18;
   localparam logic [KIND_W-1:0] KIND_NE         = 5'd19;
   localparam logic [KIND_W-1:0] KIND_ASSIGN     = 5'd20;
   localparam logic [KIND_W-1:0] KIND_EQ         = 5'd21;
   localparam logic [KIND_W-1:0] KIND_SEMI       = 5'd22;
   localparam logic [KIND_W-1:0] KIND_UNEXPECTED = 5'd23;
   localparam logic [KIND_W-1:0] KIND_TOO_LONG   = 5'd24;

   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

   localparam logic [31:0] KW_EXIT = "exit";
   localparam logic [31:0] KW_VAR  = "var";
   localparam logic [31:0] KW_IF   = "if";
   localparam logic [31:0] KW_ELSE = "else";

   typedef enum logic [2:0] {
      PEND_NONE, PEND_SLASH, PEND_LT, PEND_GT, PEND_BANG, PEND_EQ
   } pend_type;

   typedef enum logic [1:0] {
      CMD_APPEND, CMD_EMIT, CMD_RUN
   } cmd_op_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_READ, BK_SEND
   } back_state_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [KIND_W-1:0]   kind;
      logic [LINE_W-1:0]   line;
      logic [COL_W-1:0]    col;
      logic [CHAR_W-1:0]   ch;
      logic [LEN_W-1:0]    len;
      logic                last;
   } cmd_type;

   function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input pend_type p);
      case (p)
         PEND_LT:   return KIND_LT;
         PEND_GT:   return KIND_GT;
         PEND_BANG: return KIND_BANG;
         PEND_EQ:   return KIND_ASSIGN;
         default:   return KIND_SLASH;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] double_kind(input pend_type p);
      case (p)
         PEND_LT:   return KIND_LE;
         PEND_GT:   return KIND_GE;
         PEND_BANG: return KIND_NE;
         PEND_EQ:   return KIND_EQ;
         default:   return KIND_SLASH;
      endcase
   endfunction

   // true when character c at position pos matches keyword kw of length klen
   function automatic logic kw_step(input logic [31:0] kw, input logic [2:0] klen,
                                    input logic [LEN_W-1:0] pos,
                                    input logic [CHAR_W-1:0] c);
      logic [LEN_W-1:0] rel;
      logic [1:0]       idx;
      rel = LEN_W'(klen) - pos - LEN_W'(1);
      idx = rel[1:0];
      return (pos < LEN_W'(klen)) && (c == kw[{idx, 3'b000} +: 8]);
   endfunction

endpackage

### src/source_text_lexer.sv
// Character-serial lexer: one source byte per req item, tokens out as rsp items.
// The front end takes a byte and turns it into up to three queued commands,
// one pushed per cycle while the queue has room; the next byte is taken once
// they are all in the queue. When the back end replays identifier or number
// text, each character is read from the word memory before it reaches the
// output register. Identifier and number tokens arrive as runs with text_last
// on the final character; batch_last marks the last item caused by one input
// byte.
module source_text_lexer #(
   parameter int MAX_WORD    = slex_pkg::MAX_WORD_DEF,
   parameter int QUEUE_DEPTH = slex_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [slex_pkg::CHAR_W-1:0]  req_character,
   input  logic                         req_source_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [slex_pkg::KIND_W-1:0]  rsp_token_kind,
   output logic [slex_pkg::LINE_W-1:0]  rsp_line,
   output logic [slex_pkg::COL_W-1:0]   rsp_column,
   output logic [slex_pkg::CHAR_W-1:0]  rsp_text_char,
   output logic                         rsp_text_last,
   output logic                         rsp_batch_last
);

   logic              push_valid, push_ready, pop_valid, pop_ready;
   slex_pkg::cmd_type push_cmd, pop_cmd;

   slex_front #(.MAX_WORD(MAX_WORD)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_character  (req_character),
      .req_source_end (req_source_end),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd),
      .push_ready     (push_ready)
   );

   slex_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   slex_back #(.MAX_WORD(MAX_WORD)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd            (pop_cmd),
      .cmd_ready      (pop_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_kind (rsp_token_kind),
      .rsp_line       (rsp_line),
      .rsp_column     (rsp_column),
      .rsp_text_char  (rsp_text_char),
      .rsp_text_last  (rsp_text_last),
      .rsp_batch_last (rsp_batch_last)
   );

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !push_valid)
      else $error("front takes a byte while commands are still pending");

   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      push_valid && !push_ready |=> push_valid && $stable(push_cmd))
      else $error("queued command lost while the queue is full");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= slex_pkg::KIND_TOO_LONG)
      else $error("token kind out of range");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == slex_pkg::KIND_UNEXPECTED ||
                    rsp_token_kind == slex_pkg::KIND_TOO_LONG) |-> rsp_text_last)
      else $error("error item not marked as end of token");

endmodule

### src/slex_front.sv
module slex_front #(
   parameter int MAX_WORD = slex_pkg::MAX_WORD_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [slex_pkg::CHAR_W-1:0] req_character,
   input  logic                        req_source_end,
   output logic                        push_valid,
   output slex_pkg::cmd_type           push_cmd,
   input  logic                        push_ready
);

   localparam int LW = slex_pkg::LEN_W;

   logic [LW-1:0]                wlen_ff, wlen_in;
   logic                         wnum_ff, wnum_in;
   logic                         m_exit_ff, m_exit_in, m_var_ff, m_var_in;
   logic                         m_if_ff, m_if_in, m_else_ff, m_else_in;
   slex_pkg::pend_type           pend_ff, pend_in;
   logic                         incom_ff, incom_in;
   logic                         halt_ff, halt_in;
   logic [slex_pkg::LINE_W-1:0]  line_ff, line_in;
   logic [slex_pkg::COL_W-1:0]   col_ff, col_in;
   logic [2:0]                   slot_valid_ff, slot_valid_in;
   slex_pkg::cmd_type            slot_ff [3];
   slex_pkg::cmd_type            slot_in [3];
   logic                         accept;

   function automatic slex_pkg::cmd_type make_cmd(
      input slex_pkg::cmd_op_type op, input logic [slex_pkg::KIND_W-1:0] kind,
      input logic [slex_pkg::LINE_W-1:0] line, input logic [slex_pkg::COL_W-1:0] col,
      input logic [slex_pkg::CHAR_W-1:0] ch, input logic [LW-1:0] len);
      slex_pkg::cmd_type r;
      r.op   = op;
      r.kind = kind;
      r.line = line;
      r.col  = col;
      r.ch   = ch;
      r.len  = len;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic slex_pkg::cmd_type flush_cmd(
      input logic [LW-1:0] len, input logic num, input logic me, input logic mv,
      input logic mi, input logic ml, input logic [slex_pkg::LINE_W-1:0] line,
      input logic [slex_pkg::COL_W-1:0] col);
      logic [slex_pkg::KIND_W-1:0] k;
      logic                        hit;
      hit = 1'b1;
      k   = slex_pkg::KIND_EXIT;
      if (num) begin
         hit = 1'b0;
      end else if (me && len == LW'(4)) begin
         k = slex_pkg::KIND_EXIT;
      end else if (mv && len == LW'(3)) begin
         k = slex_pkg::KIND_VAR;
      end else if (mi && len == LW'(2)) begin
         k = slex_pkg::KIND_IF;
      end else if (ml && len == LW'(4)) begin
         k = slex_pkg::KIND_ELSE;
      end else begin
         hit = 1'b0;
      end
      if (hit) begin
         return make_cmd(slex_pkg::CMD_EMIT, k, line, col, '0, '0);
      end
      return make_cmd(slex_pkg::CMD_RUN,
                      num ? slex_pkg::KIND_INT : slex_pkg::KIND_IDENT,
                      line, col, '0, len);
   endfunction

   assign req_ready = (slot_valid_ff == 3'b000);
   assign accept    = req_valid && req_ready;
   assign push_valid = |slot_valid_ff;
   assign push_cmd   = slot_valid_ff[0] ? slot_ff[0] :
                       slot_valid_ff[1] ? slot_ff[1] : slot_ff[2];

   always_comb begin : classify
      logic [slex_pkg::CHAR_W-1:0] c;
      logic [slex_pkg::COL_W-1:0]  prev;
      logic                        done, newline, cont;
      logic [2:0]                  outs;
      c       = req_character;
      prev    = (col_ff == '0) ? '0 : col_ff - slex_pkg::COL_W'(1);
      done    = 1'b0;
      newline = 1'b0;
      cont    = 1'b0;
      wlen_in = wlen_ff;
      wnum_in = wnum_ff;
      m_exit_in = m_exit_ff;
      m_var_in  = m_var_ff;
      m_if_in   = m_if_ff;
      m_else_in = m_else_ff;
      pend_in  = pend_ff;
      incom_in = incom_ff;
      halt_in  = halt_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      slot_valid_in = 3'b000;
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = '0;
      end

      if (!halt_ff) begin
         if (incom_ff) begin
            if (c != slex_pkg::CH_NL) begin
               done = 1'b1;
            end else begin
               incom_in = 1'b0;
            end
         end else if (pend_ff != slex_pkg::PEND_NONE) begin
            pend_in = slex_pkg::PEND_NONE;
            if (pend_ff == slex_pkg::PEND_SLASH && c == slex_pkg::CH_SLASH) begin
               incom_in = 1'b1;
               done     = 1'b1;
            end else if (pend_ff != slex_pkg::PEND_SLASH && c == slex_pkg::CH_EQUAL) begin
               slot_valid_in[0] = 1'b1;
               slot_in[0] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::double_kind(pend_ff),
                                     line_ff, col_ff, '0, '0);
               done = 1'b1;
            end else begin
               slot_valid_in[0] = 1'b1;
               slot_in[0] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::single_kind(pend_ff),
                                     line_ff, prev, '0, '0);
            end
         end else if (wlen_ff != '0) begin
            cont = wnum_ff ? slex_pkg::is_digit(c)
                           : (slex_pkg::is_alpha(c) || slex_pkg::is_digit(c));
            if (cont) begin
               done = 1'b1;
               slot_valid_in[0] = 1'b1;
               if (wlen_ff >= LW'(MAX_WORD)) begin
                  slot_in[0] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_TOO_LONG,
                                        line_ff, col_ff, c, '0);
                  halt_in = 1'b1;
               end else begin
                  slot_in[0] = make_cmd(slex_pkg::CMD_APPEND, '0, line_ff, col_ff,
                                        c, wlen_ff);
                  wlen_in   = wlen_ff + LW'(1);
                  m_exit_in = m_exit_ff && slex_pkg::kw_step(slex_pkg::KW_EXIT, 3'd4, wlen_ff, c);
                  m_var_in  = m_var_ff && slex_pkg::kw_step(slex_pkg::KW_VAR, 3'd3, wlen_ff, c);
                  m_if_in   = m_if_ff && slex_pkg::kw_step(slex_pkg::KW_IF, 3'd2, wlen_ff, c);
                  m_else_in = m_else_ff && slex_pkg::kw_step(slex_pkg::KW_ELSE, 3'd4, wlen_ff, c);
               end
            end else begin
               slot_valid_in[0] = 1'b1;
               slot_in[0] = flush_cmd(wlen_ff, wnum_ff, m_exit_ff, m_var_ff, m_if_ff,
                                      m_else_ff, line_ff, prev);
               wlen_in = '0;
               wnum_in = 1'b0;
            end
         end

         if (!done) begin
            if (slex_pkg::is_alpha(c) || slex_pkg::is_digit(c)) begin
               slot_valid_in[1] = 1'b1;
               slot_in[1] = make_cmd(slex_pkg::CMD_APPEND, '0, line_ff, col_ff, c, '0);
               wlen_in   = LW'(1);
               wnum_in   = slex_pkg::is_digit(c);
               m_exit_in = slex_pkg::kw_step(slex_pkg::KW_EXIT, 3'd4, '0, c);
               m_var_in  = slex_pkg::kw_step(slex_pkg::KW_VAR, 3'd3, '0, c);
               m_if_in   = slex_pkg::kw_step(slex_pkg::KW_IF, 3'd2, '0, c);
               m_else_in = slex_pkg::kw_step(slex_pkg::KW_ELSE, 3'd4, '0, c);
            end else begin
               case (c)
                  slex_pkg::CH_LPAREN: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_LPAREN,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_RPAREN: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_RPAREN,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_LBRACE: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_LBRACE,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_RBRACE: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_RBRACE,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_PLUS: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_PLUS,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_MINUS: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_MINUS,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_STAR: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_STAR,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_SEMI: begin
                     slot_valid_in[1] = 1'b1;
                     slot_in[1] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::KIND_SEMI,
                                           line_ff, col_ff, '0, '0);
                  end
                  slex_pkg::CH_SLASH: pend_in = slex_pkg::PEND_SLASH;
                  slex_pkg::CH_LT:    pend_in = slex_pkg::PEND_LT;
                  slex_pkg::CH_GT:    pend_in = slex_pkg::PEND_GT;
                  slex_pkg::CH_BANG:  pend_in = slex_pkg::PEND_BANG;
                  slex_pkg::CH_EQUAL: pend_in = slex_pkg::PEND_EQ;
                  slex_pkg::CH_NL:    newline = 1'b1;
                  default: begin
                     if (!slex_pkg::is_space(c)) begin
                        slot_valid_in[1] = 1'b1;
                        slot_in[1] = make_cmd(slex_pkg::CMD_EMIT,
                                              slex_pkg::KIND_UNEXPECTED,
                                              line_ff, col_ff, c, '0);
                        halt_in = 1'b1;
                     end
                  end
               endcase
            end
         end

         if (!halt_in) begin
            if (newline) begin
               if (line_ff != '1) begin
                  line_in = line_ff + slex_pkg::LINE_W'(1);
               end
               col_in = '0;
            end else if (col_ff != '1) begin
               col_in = col_ff + slex_pkg::COL_W'(1);
            end
         end
      end

      if (req_source_end) begin
         if (!halt_in) begin
            if (wlen_in != '0) begin
               slot_valid_in[2] = 1'b1;
               slot_in[2] = flush_cmd(wlen_in, wnum_in, m_exit_in, m_var_in, m_if_in,
                                      m_else_in, line_ff, col_ff);
            end else if (pend_in != slex_pkg::PEND_NONE) begin
               slot_valid_in[2] = 1'b1;
               slot_in[2] = make_cmd(slex_pkg::CMD_EMIT, slex_pkg::single_kind(pend_in),
                                     line_ff, col_ff, '0, '0);
            end
         end
         wlen_in  = '0;
         wnum_in  = 1'b0;
         pend_in  = slex_pkg::PEND_NONE;
         incom_in = 1'b0;
         halt_in  = 1'b0;
         line_in  = slex_pkg::LINE_W'(1);
         col_in   = '0;
      end

      for (int i = 0; i < 3; i++) begin
         outs[i] = slot_valid_in[i] && (slot_in[i].op != slex_pkg::CMD_APPEND);
      end
      slot_in[2].last = outs[2];
      slot_in[1].last = outs[1] && !outs[2];
      slot_in[0].last = outs[0] && !outs[1] && !outs[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= '0;
         wnum_ff  <= 1'b0;
         pend_ff  <= slex_pkg::PEND_NONE;
         incom_ff <= 1'b0;
         halt_ff  <= 1'b0;
         line_ff  <= slex_pkg::LINE_W'(1);
         col_ff   <= '0;
         slot_valid_ff <= 3'b000;
      end else if (accept) begin
         wlen_ff  <= wlen_in;
         wnum_ff  <= wnum_in;
         pend_ff  <= pend_in;
         incom_ff <= incom_in;
         halt_ff  <= halt_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         slot_valid_ff <= slot_valid_in;
      end else if (push_valid && push_ready) begin
         if (slot_valid_ff[0]) begin
            slot_valid_ff[0] <= 1'b0;
         end else if (slot_valid_ff[1]) begin
            slot_valid_ff[1] <= 1'b0;
         end else begin
            slot_valid_ff[2] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         m_exit_ff <= m_exit_in;
         m_var_ff  <= m_var_in;
         m_if_ff   <= m_if_in;
         m_else_ff <= m_else_in;
         for (int i = 0; i < 3; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

endmodule

### src/slex_fifo.sv
module slex_fifo #(
   parameter int DEPTH = slex_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  slex_pkg::cmd_type push_cmd,
   output logic              push_ready,
   output logic              pop_valid,
   output slex_pkg::cmd_type pop_cmd,
   input  logic              pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   slex_pkg::cmd_type  data_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = data_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### src/slex_back.sv
module slex_back #(
   parameter int MAX_WORD = slex_pkg::MAX_WORD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  slex_pkg::cmd_type            cmd,
   output logic                         cmd_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [slex_pkg::KIND_W-1:0]  rsp_token_kind,
   output logic [slex_pkg::LINE_W-1:0]  rsp_line,
   output logic [slex_pkg::COL_W-1:0]   rsp_column,
   output logic [slex_pkg::CHAR_W-1:0]  rsp_text_char,
   output logic                         rsp_text_last,
   output logic                         rsp_batch_last
);

   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LW = slex_pkg::LEN_W;

   slex_pkg::back_state_type    state_ff, state_in;
   slex_pkg::cmd_type           run_ff;
   logic [LW-1:0]               idx_ff;
   logic [slex_pkg::CHAR_W-1:0] data_ff;
   logic [slex_pkg::CHAR_W-1:0] mem [MAX_WORD];
   logic                        rsp_valid_ff;
   logic [slex_pkg::KIND_W-1:0] kind_ff;
   logic [slex_pkg::LINE_W-1:0] line_ff;
   logic [slex_pkg::COL_W-1:0]  col_ff;
   logic [slex_pkg::CHAR_W-1:0] ch_ff;
   logic                        tlast_ff, blast_ff;
   logic                        can_load, mem_we, mem_re, load_emit, load_char;
   logic                        start_run, run_end;

   assign can_load = !rsp_valid_ff || rsp_ready;
   assign run_end  = (idx_ff == run_ff.len - LW'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slex_pkg::BK_IDLE: begin
            if (cmd_valid && cmd.op == slex_pkg::CMD_RUN) begin
               state_in = slex_pkg::BK_READ;
            end
         end
         slex_pkg::BK_READ: state_in = slex_pkg::BK_SEND;
         slex_pkg::BK_SEND: begin
            if (can_load) begin
               state_in = run_end ? slex_pkg::BK_IDLE : slex_pkg::BK_READ;
            end
         end
         default: state_in = slex_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_ready = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      load_emit = 1'b0;
      load_char = 1'b0;
      start_run = 1'b0;
      case (state_ff)
         slex_pkg::BK_IDLE: begin
            case (cmd.op)
               slex_pkg::CMD_APPEND: begin
                  cmd_ready = 1'b1;
                  mem_we    = cmd_valid;
               end
               slex_pkg::CMD_EMIT: begin
                  cmd_ready = can_load;
                  load_emit = cmd_valid && can_load;
               end
               slex_pkg::CMD_RUN: begin
                  cmd_ready = 1'b1;
                  start_run = cmd_valid;
               end
               default: cmd_ready = 1'b1;
            endcase
         end
         slex_pkg::BK_READ: mem_re = 1'b1;
         slex_pkg::BK_SEND: load_char = can_load;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slex_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_emit || load_char) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd.len[IDX_W-1:0]] <= cmd.ch;
      end
      if (mem_re) begin
         data_ff <= mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (start_run) begin
         run_ff <= cmd;
         idx_ff <= '0;
      end else if (load_char) begin
         idx_ff <= idx_ff + LW'(1);
      end
      if (load_emit) begin
         kind_ff  <= cmd.kind;
         line_ff  <= cmd.line;
         col_ff   <= cmd.col;
         ch_ff    <= cmd.ch;
         tlast_ff <= 1'b1;
         blast_ff <= cmd.last;
      end else if (load_char) begin
         kind_ff  <= run_ff.kind;
         line_ff  <= run_ff.line;
         col_ff   <= run_ff.col;
         ch_ff    <= data_ff;
         tlast_ff <= run_end;
         blast_ff <= run_end && run_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_kind = kind_ff;
   assign rsp_line       = line_ff;
   assign rsp_column     = col_ff;
   assign rsp_text_char  = ch_ff;
   assign rsp_text_last  = tlast_ff;
   assign rsp_batch_last = blast_ff;

endmodule
